// ===== hw/rtl/rcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Rice code decoder package
// Shared widths, word types and the control and status bundles of the
// bit-serial code word accumulator.
// ----------------------------------------------------------------------------
package rcd_pkg;

   localparam int RCD_VALUE_WIDTH    = 32;
   localparam int RCD_RESULT_WIDTH   = 32;
   localparam int RCD_QUOTIENT_WIDTH = 32;
   localparam int RCD_K_WIDTH        = 5;
   localparam int RCD_BYTE_BITS      = 8;
   localparam int RCD_COUNT_WIDTH    = 4;

   typedef struct packed {
      logic [RCD_BYTE_BITS-1:0]   data_byte;
      logic [RCD_COUNT_WIDTH-1:0] valid_bits;
      logic                       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [RCD_RESULT_WIDTH-1:0]        mapped_value;
      logic signed [RCD_RESULT_WIDTH-1:0] residual;
      logic                               truncated;
      logic                               last_of_run;
   } rsp_type;

   typedef struct packed {
      logic step;
      logic data_bit;
      logic flush;
   } rcd_ctrl_type;

   typedef struct packed {
      logic word_done;
      logic in_word;
   } rcd_stat_type;

endpackage

// ===== hw/rtl/rcd_word_acc.sv =====
// ----------------------------------------------------------------------------
// Rice code word accumulator
// Consumes one stream bit per step: counts the unary quotient, shifts in the
// remainder bits and forms the mapped value when a code word completes.
// ----------------------------------------------------------------------------
module rcd_word_acc
   import rcd_pkg::*;
#(
   parameter int VALUE_WIDTH = RCD_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rcd_ctrl_type           ctrl,
   input  logic [RCD_K_WIDTH-1:0] rice_k,
   output rcd_stat_type           stat,
   output logic [VALUE_WIDTH-1:0] mapped
);

   logic                          in_rem_ff, in_rem_in;
   logic [RCD_QUOTIENT_WIDTH-1:0] quot_ff, quot_in;
   logic [VALUE_WIDTH-1:0]        acc_ff, acc_in;
   logic [RCD_K_WIDTH-1:0]        seen_ff, seen_in;

   logic [VALUE_WIDTH-1:0] acc_next;
   logic [RCD_K_WIDTH-1:0] seen_next;
   logic                   done;

   assign acc_next  = {acc_ff[VALUE_WIDTH-2:0], ctrl.data_bit};
   assign seen_next = seen_ff + 1'b1;

   always_comb begin
      if (in_rem_ff) begin
         done = (seen_next >= rice_k);
      end else begin
         done = !ctrl.data_bit && (rice_k == '0);
      end
   end

   // mapped value as it stands after this bit
   assign mapped = (quot_ff[VALUE_WIDTH-1:0] << rice_k) | (in_rem_ff ? acc_next : acc_ff);

   assign stat.word_done = done;
   assign stat.in_word   = in_rem_ff || (quot_ff != '0);

   always_comb begin
      in_rem_in = in_rem_ff;
      quot_in   = quot_ff;
      acc_in    = acc_ff;
      seen_in   = seen_ff;
      if (ctrl.flush || (ctrl.step && done)) begin
         in_rem_in = 1'b0;
         quot_in   = '0;
         acc_in    = '0;
         seen_in   = '0;
      end else if (ctrl.step) begin
         if (in_rem_ff) begin
            acc_in  = acc_next;
            seen_in = seen_next;
         end else if (ctrl.data_bit) begin
            quot_in = quot_ff + 1'b1;
         end else begin
            in_rem_in = 1'b1;
            acc_in    = '0;
            seen_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_rem_ff <= 1'b0;
         quot_ff   <= '0;
         acc_ff    <= '0;
         seen_ff   <= '0;
      end else begin
         in_rem_ff <= in_rem_in;
         quot_ff   <= quot_in;
         acc_ff    <= acc_in;
         seen_ff   <= seen_in;
      end
   end

endmodule

// ===== hw/rtl/rice_code_decoder.sv =====
// ----------------------------------------------------------------------------
// Rice code decoder
// Golomb-Rice stream decoder with zigzag inverse mapping of each code word.
// ----------------------------------------------------------------------------
// Usage:
//  req_* takes one stream word per handshake: a byte consumed MSB first, the
//  number of leading stream bits (values above eight count as eight) and an
//  end-of-stream flag. rsp_* returns one word per finished code word, plus a
//  truncation word when the stream ends inside a code word; last_of_run marks
//  the final result word caused by an input word.
//  csr_wr_en/csr_wr_data write rice_k; write it only while the block is idle.
//  Bits are decoded one per cycle in the shift register while no finished
//  result is held up by a stalled output; an input word passes through
//  acceptance, the bit steps, the count-exhausted step, the end check and
//  the final drain, from which its last result word leaves.
//  One finished result is held back until the next one (or the end of the
//  word) decides its last_of_run flag; a stalled output register holds the
//  bit loop only when a second result must leave. req_stall is low whenever
//  the decoder is idle, even with a result still waiting in the output.
//  Reset clears rice_k, the code word state and both valid flags.
// ----------------------------------------------------------------------------
module rice_code_decoder
   import rcd_pkg::*;
#(
   parameter int VALUE_WIDTH = RCD_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_wr_en,
   input  logic [RCD_K_WIDTH-1:0] csr_wr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BITS,
      ST_CHECK,
      ST_DRAIN
   } state_type;

   state_type                  state_ff, state_in;
   logic [RCD_K_WIDTH-1:0]     rice_k_ff, rice_k_in;
   logic [RCD_BYTE_BITS-1:0]   sh_ff, sh_in;
   logic [RCD_COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                       eos_ff, eos_in;
   logic                       pend_valid_ff, pend_valid_in;
   logic [VALUE_WIDTH-1:0]     pend_val_ff, pend_val_in;
   logic                       pend_trunc_ff, pend_trunc_in;
   logic                       out_valid_ff, out_valid_in;
   rsp_type                    out_ff, out_in;

   rcd_ctrl_type           ctrl;
   rcd_stat_type           stat;
   logic [VALUE_WIDTH-1:0] mapped;
   logic                   out_free;
   logic                   push;
   logic                   push_last;
   logic [RCD_RESULT_WIDTH-1:0] pend_ext;
   logic [RCD_RESULT_WIDTH-1:0] half;
   logic [RCD_COUNT_WIDTH-1:0]  nbits;

   rcd_word_acc #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_word_acc (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .rice_k (rice_k_ff),
      .stat   (stat),
      .mapped (mapped)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;

   assign nbits = (req_data.valid_bits > RCD_COUNT_WIDTH'(RCD_BYTE_BITS)) ?
                  RCD_COUNT_WIDTH'(RCD_BYTE_BITS) : req_data.valid_bits;

   assign pend_ext = RCD_RESULT_WIDTH'(pend_val_ff);
   assign half     = pend_ext >> 1;

   assign rice_k_in = csr_wr_en ? csr_wr_data : rice_k_ff;

   always_comb begin
      state_in      = state_ff;
      sh_in         = sh_ff;
      cnt_in        = cnt_ff;
      eos_in        = eos_ff;
      pend_valid_in = pend_valid_ff;
      pend_val_in   = pend_val_ff;
      pend_trunc_in = pend_trunc_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_in        = out_ff;
      ctrl          = '0;
      ctrl.data_bit = sh_ff[RCD_BYTE_BITS-1];
      push          = 1'b0;
      push_last     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sh_in    = req_data.data_byte;
               cnt_in   = nbits;
               eos_in   = req_data.end_of_stream;
               state_in = ST_BITS;
            end
         end
         ST_BITS: begin
            if (cnt_ff == '0) begin
               state_in = ST_CHECK;
            end else if (!(stat.word_done && pend_valid_ff && !out_free)) begin
               ctrl.step = 1'b1;
               sh_in     = {sh_ff[RCD_BYTE_BITS-2:0], 1'b0};
               cnt_in    = cnt_ff - 1'b1;
               if (stat.word_done) begin
                  push          = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_val_in   = mapped;
                  pend_trunc_in = 1'b0;
               end
            end
         end
         ST_CHECK: begin
            if (eos_ff && stat.in_word) begin
               if (!pend_valid_ff || out_free) begin
                  ctrl.flush    = 1'b1;
                  push          = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_val_in   = '0;
                  pend_trunc_in = 1'b1;
                  state_in      = ST_DRAIN;
               end
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               push          = 1'b1;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (push) begin
         out_valid_in        = 1'b1;
         out_in.mapped_value = pend_ext;
         out_in.residual     = pend_ext[0] ? ~half : half;
         out_in.truncated    = pend_trunc_ff;
         out_in.last_of_run  = push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rice_k_ff     <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rice_k_ff     <= rice_k_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      sh_ff         <= sh_in;
      cnt_ff        <= cnt_in;
      eos_ff        <= eos_in;
      pend_val_ff   <= pend_val_in;
      pend_trunc_ff <= pend_trunc_in;
      out_ff        <= out_in;
   end

   // a pushed result never overwrites a word still waiting at the output
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("result pushed into a full output register");

   // nothing is left pending once the decoder is idle again
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending result left behind in idle");

   a_trunc_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.truncated) |->
         (rsp_data.mapped_value == '0 && rsp_data.residual == '0 && rsp_data.last_of_run))
      else $error("truncation word with payload or not last");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("decoder not busy after accepting a word");

endmodule

// ===== tb/sv/rcd_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rice decoder scoreboard
// Bit-serial prediction of the Golomb-Rice decode and zigzag inverse. Each
// accepted stream word adds its expected result words to an ordered store.
// Each accepted result word is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
package rcd_tb_pkg;
   import rcd_pkg::*;

   class rice_word_scoreboard;
      logic [RCD_K_WIDTH-1:0]        rice_k;
      logic                          in_remainder;
      logic [RCD_QUOTIENT_WIDTH-1:0] quotient_count;
      logic [RCD_VALUE_WIDTH-1:0]    remainder_acc;
      logic [RCD_K_WIDTH-1:0]        bits_seen;
      rsp_type                       expected_words[$];
      int                            errors;
      int                            checked;
      int                            truncations;

      function new();
         rice_k = '0;
         errors = 0;
         checked = 0;
         truncations = 0;
         clear_word();
      endfunction

      function void clear_word();
         in_remainder = 1'b0;
         quotient_count = '0;
         remainder_acc = '0;
         bits_seen = '0;
      endfunction

      function void set_k(logic [RCD_K_WIDTH-1:0] k);
         rice_k = k;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function rsp_type finish_word();
         rsp_type r;
         logic [RCD_VALUE_WIDTH-1:0] m;
         m = (quotient_count << rice_k) | remainder_acc;
         r = '0;
         r.mapped_value = m;
         r.residual = m[0] ? ~(m >> 1) : (m >> 1);
         clear_word();
         return r;
      endfunction

      function void note_stream_word(req_type w);
         rsp_type run[$];
         rsp_type r;
         int      nbits;
         logic    b;
         nbits = (w.valid_bits > RCD_BYTE_BITS) ? RCD_BYTE_BITS : int'(w.valid_bits);
         for (int i = 0; i < nbits; i++) begin
            b = w.data_byte[RCD_BYTE_BITS-1-i];
            if (!in_remainder) begin
               if (b) begin
                  quotient_count = quotient_count + 1;
               end else if (rice_k == 0) begin
                  run.push_back(finish_word());
               end else begin
                  in_remainder = 1'b1;
                  remainder_acc = '0;
                  bits_seen = '0;
               end
            end else begin
               remainder_acc = {remainder_acc[RCD_VALUE_WIDTH-2:0], b};
               bits_seen = bits_seen + 1'b1;
               if (bits_seen >= rice_k) begin
                  run.push_back(finish_word());
               end
            end
         end
         if (w.end_of_stream && (in_remainder || quotient_count != 0)) begin
            r = '0;
            r.truncated = 1'b1;
            run.push_back(r);
            clear_word();
         end
         for (int j = 0; j < run.size(); j++) begin
            r = run[j];
            r.last_of_run = (j == run.size() - 1);
            expected_words.push_back(r);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp_word;
         checked++;
         if (got.truncated) truncations++;
         if (expected_words.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("ERROR: unexpected result word map=%h res=%h trunc=%b last=%b",
                        got.mapped_value, got.residual, got.truncated, got.last_of_run);
            end
            return;
         end
         exp_word = expected_words.pop_front();
         if (got.mapped_value !== exp_word.mapped_value ||
             got.residual !== exp_word.residual ||
             got.truncated !== exp_word.truncated ||
             got.last_of_run !== exp_word.last_of_run) begin
            errors++;
            if (errors <= 10) begin
               $display("ERROR: result word %0d exp map=%h res=%h trunc=%b last=%b",
                        checked, exp_word.mapped_value, exp_word.residual,
                        exp_word.truncated, exp_word.last_of_run);
               $display("       got map=%h res=%h trunc=%b last=%b",
                        got.mapped_value, got.residual, got.truncated, got.last_of_run);
            end
         end
      endfunction
   endclass

endpackage

// ===== tb/sv/rice_code_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rice code decoder testbench
// Directed stream words cover full, empty and oversized bit counts, long
// unary runs, the all-ones mapped value, rice_k changes inside a code word
// and truncated streams; random phases then sweep rice_k and idle patterns
// while a scoreboard predicts every result word.
// ----------------------------------------------------------------------------
module rice_code_decoder_tb
   import rcd_pkg::*;
   import rcd_tb_pkg::*;
();

   localparam int LIMIT_CYCLES  = 400000;
   localparam int SETTLE_CYCLES = 24;
   localparam int PHASE_WORDS   = 25;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_data;
   logic                   csr_wr_en;
   logic [RCD_K_WIDTH-1:0] csr_wr_data;

   rice_word_scoreboard sb;
   int cycle_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int words_sent = 0;

   rice_code_decoder DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d result words outstanding",
                  cycle_count, sb.pending());
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      rsp_stall <= (receiver_stall_pct > 0) && ($urandom_range(99) < receiver_stall_pct);
   end

   function automatic req_type mk(logic [7:0] b, logic [3:0] n, logic e);
      req_type w;
      w.data_byte = b;
      w.valid_bits = n;
      w.end_of_stream = e;
      return w;
   endfunction

   function automatic req_type random_word();
      req_type w;
      int      pick;
      pick = $urandom_range(99);
      w.data_byte = 8'($urandom_range(255));
      w.valid_bits = 4'($urandom_range(8, 1));
      if (pick < 15) begin
         w.data_byte = 8'hFF;
      end else if (pick < 25) begin
         w.valid_bits = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 9));
      end
      w.end_of_stream = ($urandom_range(9) == 0);
      return w;
   endfunction

   task automatic set_idle(idle_mode_type mode);
      unique case (mode)
         IDLE_NONE: begin
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
         end
         IDLE_SENDER: begin
            sender_idle_pct = 64;
            receiver_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            sender_idle_pct = 0;
            receiver_stall_pct = 64;
         end
         default: begin
            sender_idle_pct = 22;
            receiver_stall_pct = 22;
         end
      endcase
   endtask

   task automatic send_word(req_type w);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      sb.note_stream_word(w);
      words_sent++;
   endtask

   // hold off until every expected word is back and the bit loop has settled
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_k(logic [RCD_K_WIDTH-1:0] k);
      csr_wr_en <= 1'b1;
      csr_wr_data <= k;
      @(posedge clock);
      sb.set_k(k);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int k_plan[8];
      int k;
      sb = new();
      k_plan = '{1, 31, 0, 4, 2, 7, 3, 0};
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      rsp_stall <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idle(IDLE_NONE);
      write_k(5'd0);
      send_word(mk(8'h00, 4'd8, 1'b0));
      send_word(mk(8'hFF, 4'd8, 1'b0));
      send_word(mk(8'hFF, 4'd15, 1'b0));
      send_word(mk(8'h80, 4'd1, 1'b0));
      send_word(mk(8'h00, 4'd0, 1'b1));
      send_word(mk(8'hB5, 4'd12, 1'b1));
      send_word(mk(8'h7F, 4'd8, 1'b1));
      send_word(mk(8'h00, 4'd4, 1'b1));
      drain();
      // leave a word inside its remainder, then shrink rice_k under it
      write_k(5'd5);
      send_word(mk(8'h20, 4'd3, 1'b0));
      drain();
      write_k(5'd1);
      send_word(mk(8'h80, 4'd1, 1'b0));
      drain();
      write_k(5'd3);
      send_word(mk(8'hA5, 4'd8, 1'b0));
      send_word(mk(8'h3C, 4'd9, 1'b0));
      send_word(mk(8'h5A, 4'd8, 1'b1));
      drain();
      // all-ones mapped value, then a quotient shifted out of range
      write_k(5'd31);
      send_word(mk(8'hBF, 4'd8, 1'b0));
      repeat (3) send_word(mk(8'hFF, 4'd8, 1'b0));
      send_word(mk(8'hFF, 4'd1, 1'b0));
      send_word(mk(8'hFE, 4'd8, 1'b0));
      repeat (3) send_word(mk(8'h00, 4'd8, 1'b0));
      send_word(mk(8'h00, 4'd7, 1'b1));
      drain();

      for (int p = 0; p < 8; p++) begin
         k = (p == 6) ? $urandom_range(31) : k_plan[p];
         write_k(5'(k));
         set_idle(idle_mode_type'(p % 4));
         repeat (PHASE_WORDS) send_word(random_word());
         drain();
      end
      set_idle(IDLE_NONE);

      $display("Sent %0d stream words; checked %0d result words, %0d of them truncations.",
               words_sent, sb.checked, sb.truncations);
      $display("rice_k swept 0..31 under four idle patterns; %0d mismatches.", sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
